FILE: rtl/core/qts_pkg.sv
`default_nettype none

package qts_pkg;

    localparam int SET_SLOTS   = 8;
    localparam int QUOTE_SLOTS = 4;
    localparam int LINE_MAX    = 1024;
    localparam int QUOTE_EFF   = (QUOTE_SLOTS < 4) ? QUOTE_SLOTS : 4;

    localparam int CNT_W   = 10;
    localparam int CNT_CAP = ((LINE_MAX - 1) < 1023) ? (LINE_MAX - 1) : 1023;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int CFG_IDX_W = 3;

    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [7:0]       t_byte;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cnt CNT_CAP_V = t_cnt'(CNT_CAP);

    localparam t_cfg_idx CFG_SEPARATOR   = 3'd0;
    localparam t_cfg_idx CFG_SINGLE      = 3'd1;
    localparam t_cfg_idx CFG_COMMENT     = 3'd2;
    localparam t_cfg_idx CFG_QUOTE       = 3'd3;
    localparam t_cfg_idx CFG_QUOTE_ENDS  = 3'd4;

    localparam logic [63:0] RST_SEPARATOR  = 64'h0000_0000_0D0A_0920;
    localparam logic [63:0] RST_SINGLE     = 64'h0;
    localparam logic [63:0] RST_COMMENT    = 64'h23;
    localparam logic [31:0] RST_QUOTE      = 32'h0000_2722;
    localparam logic        RST_QUOTE_ENDS = 1'b1;

    localparam t_byte CH_NUL  = 8'h00;
    localparam t_byte CH_LBRK = 8'h5B;
    localparam t_byte CH_RBRK = 8'h5D;
    localparam t_byte CH_LPAR = 8'h28;
    localparam t_byte CH_RPAR = 8'h29;
    localparam t_byte CH_LBRC = 8'h7B;
    localparam t_byte CH_RBRC = 8'h7D;

    typedef enum logic [3:0] {
        M_BETWEEN = 4'b0001,
        M_TOKEN   = 4'b0010,
        M_QUOTE   = 4'b0100,
        M_DISCARD = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [63:0] separator;
        logic [63:0] single;
        logic [63:0] comment;
        logic [31:0] quote;
        logic        quote_ends;
    } t_cfg;

    // dbl: token end followed by a single-character token (start2 is its start)
    typedef struct packed {
        logic  dbl;
        logic  has_char;
        t_byte out_char;
        logic  token_end;
        t_cnt  token_start;
        logic  line_end;
        t_cnt  token_count;
        t_cnt  start2;
    } t_rec;

    function automatic logic in_slots(input logic [63:0] vec, input int slots,
                                      input t_byte c);
        logic found;
        found = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (k < slots && vec[8*k +: 8] != CH_NUL && vec[8*k +: 8] == c) begin
                found = 1'b1;
            end
        end
        return found;
    endfunction

    function automatic t_byte mate_of(input t_byte c);
        t_byte m;
        case (c)
            CH_LBRK: m = CH_RBRK;
            CH_LPAR: m = CH_RPAR;
            CH_LBRC: m = CH_RBRC;
            default: m = c;
        endcase
        return m;
    endfunction

    function automatic t_cnt sat_inc(input t_cnt v);
        return (v < CNT_CAP_V) ? t_cnt'(v + 1'b1) : CNT_CAP_V;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/qts_front.sv
`default_nettype none

module qts_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire qts_pkg::t_byte i_ch,
    input  wire qts_pkg::t_cfg i_cfg,
    output qts_pkg::t_rec      o_rec,
    output logic               o_rec_push
);
    import qts_pkg::*;

    t_mode r_mode, n_mode;
    t_byte r_close, n_close;
    t_cnt  r_pos, n_pos;
    t_cnt  r_start, n_start;
    t_cnt  r_tokens, n_tokens;
    logic  r_await, n_await;

    logic is_sep, is_single, is_quote, is_comment;
    t_cnt tok1, tok2;
    logic open_tok;

    assign is_sep     = in_slots(i_cfg.separator, SET_SLOTS, i_ch);
    assign is_single  = in_slots(i_cfg.single, SET_SLOTS, i_ch);
    assign is_comment = in_slots(i_cfg.comment, SET_SLOTS, i_ch);
    assign is_quote   = in_slots({32'b0, i_cfg.quote}, QUOTE_EFF, i_ch);
    assign tok1       = sat_inc(r_tokens);
    assign tok2       = sat_inc(tok1);
    assign open_tok   = (r_mode == M_TOKEN) || (r_mode == M_QUOTE);

    always_comb begin
        n_mode     = r_mode;
        n_close    = r_close;
        n_pos      = r_pos;
        n_start    = r_start;
        n_tokens   = r_tokens;
        n_await    = r_await;
        o_rec      = '0;
        o_rec_push = 1'b0;
        if (i_accept) begin
            if (i_ch == CH_NUL) begin
                o_rec_push        = 1'b1;
                o_rec.token_end   = open_tok;
                o_rec.token_start = open_tok ? r_start : '0;
                o_rec.line_end    = 1'b1;
                o_rec.token_count = open_tok ? tok1 : r_tokens;
                n_mode   = M_BETWEEN;
                n_close  = CH_NUL;
                n_pos    = '0;
                n_start  = '0;
                n_tokens = '0;
                n_await  = 1'b1;
            end else begin
                n_pos = sat_inc(r_pos);
                unique case (r_mode)
                    M_QUOTE: begin
                        if (i_ch == r_close) begin
                            if (i_cfg.quote_ends) begin
                                n_tokens          = tok1;
                                o_rec_push        = 1'b1;
                                o_rec.token_end   = 1'b1;
                                o_rec.token_start = r_start;
                                n_mode            = M_BETWEEN;
                            end else begin
                                n_mode = M_TOKEN;
                            end
                        end else if (r_await && is_comment) begin
                            n_await = 1'b0;
                            n_mode  = M_DISCARD;
                        end else begin
                            n_await        = 1'b0;
                            o_rec_push     = 1'b1;
                            o_rec.has_char = 1'b1;
                            o_rec.out_char = i_ch;
                        end
                    end
                    M_TOKEN: begin
                        if (is_sep) begin
                            n_tokens          = tok1;
                            o_rec_push        = 1'b1;
                            o_rec.token_end   = 1'b1;
                            o_rec.token_start = r_start;
                            n_mode            = M_BETWEEN;
                        end else if (is_single) begin
                            o_rec_push        = 1'b1;
                            o_rec.token_end   = 1'b1;
                            o_rec.token_start = r_start;
                            if (is_comment) begin
                                n_tokens = tok1;
                                n_mode   = M_DISCARD;
                            end else begin
                                n_tokens       = tok2;
                                o_rec.dbl      = 1'b1;
                                o_rec.has_char = 1'b1;
                                o_rec.out_char = i_ch;
                                o_rec.start2   = r_pos;
                                n_mode         = M_BETWEEN;
                            end
                        end else if (is_quote) begin
                            n_close = mate_of(i_ch);
                            n_mode  = M_QUOTE;
                        end else if (r_await && is_comment) begin
                            n_await = 1'b0;
                            n_mode  = M_DISCARD;
                        end else begin
                            n_await        = 1'b0;
                            o_rec_push     = 1'b1;
                            o_rec.has_char = 1'b1;
                            o_rec.out_char = i_ch;
                        end
                    end
                    M_BETWEEN: begin
                        if (is_sep) begin
                            n_mode = M_BETWEEN;
                        end else if (is_single) begin
                            if (is_comment) begin
                                n_mode = M_DISCARD;
                            end else begin
                                n_tokens          = tok1;
                                o_rec_push        = 1'b1;
                                o_rec.has_char    = 1'b1;
                                o_rec.out_char    = i_ch;
                                o_rec.token_end   = 1'b1;
                                o_rec.token_start = r_pos;
                            end
                        end else begin
                            n_start = r_pos;
                            if (is_quote) begin
                                n_await = 1'b1;
                                n_close = mate_of(i_ch);
                                n_mode  = M_QUOTE;
                            end else if (is_comment) begin
                                n_await = 1'b0;
                                n_mode  = M_DISCARD;
                            end else begin
                                n_await        = 1'b0;
                                n_mode         = M_TOKEN;
                                o_rec_push     = 1'b1;
                                o_rec.has_char = 1'b1;
                                o_rec.out_char = i_ch;
                            end
                        end
                    end
                    M_DISCARD: begin
                        n_mode = M_DISCARD;
                    end
                    default: begin
                        n_mode = M_BETWEEN;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_BETWEEN;
            r_close  <= CH_NUL;
            r_pos    <= '0;
            r_start  <= '0;
            r_tokens <= '0;
            r_await  <= 1'b1;
        end else begin
            r_mode   <= n_mode;
            r_close  <= n_close;
            r_pos    <= n_pos;
            r_start  <= n_start;
            r_tokens <= n_tokens;
            r_await  <= n_await;
        end
    end

    a_pos_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos <= CNT_CAP_V) && (r_tokens <= r_pos || r_tokens <= CNT_CAP_V))
        else $error("line counters beyond cap");

endmodule

`default_nettype wire

FILE: rtl/core/qts_fifo.sv
`default_nettype none

module qts_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire qts_pkg::t_rec i_rec,
    output logic               o_full,
    input  wire logic          i_pop,
    output qts_pkg::t_rec      o_head,
    output logic               o_empty
);
    import qts_pkg::*;

    t_rec r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr, r_rd;
    logic [FIFO_AW:0]   r_count, n_count;
    logic do_push, do_pop;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("queue count overflow");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0 && r_count != (FIFO_AW+1)'(FIFO_DEPTH)) |->
            (r_wr - r_rd) == r_count[FIFO_AW-1:0])
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

FILE: rtl/core/qts_back.sv
`default_nettype none

module qts_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire qts_pkg::t_rec i_head,
    input  wire logic          i_empty,
    input  wire logic          i_pop,
    output logic               o_q_pop,
    output logic               o_has_char,
    output logic [7:0]         o_out_char,
    output logic               o_token_end,
    output logic [9:0]         o_token_start,
    output logic               o_line_end,
    output logic [9:0]         o_token_count,
    output logic               o_last
);
    import qts_pkg::*;

    logic r_half, n_half;
    logic take;

    assign take = i_pop && !i_empty;

    always_comb begin
        n_half  = r_half;
        o_q_pop = 1'b0;
        if (take) begin
            if (i_head.dbl && !r_half) begin
                n_half = 1'b1;
            end else begin
                n_half  = 1'b0;
                o_q_pop = 1'b1;
            end
        end
    end

    always_comb begin
        if (i_head.dbl && !r_half) begin
            o_has_char    = 1'b0;
            o_out_char    = CH_NUL;
            o_token_end   = 1'b1;
            o_token_start = i_head.token_start;
            o_line_end    = 1'b0;
            o_token_count = '0;
            o_last        = 1'b0;
        end else if (i_head.dbl) begin
            o_has_char    = 1'b1;
            o_out_char    = i_head.out_char;
            o_token_end   = 1'b1;
            o_token_start = i_head.start2;
            o_line_end    = 1'b0;
            o_token_count = '0;
            o_last        = 1'b1;
        end else begin
            o_has_char    = i_head.has_char;
            o_out_char    = i_head.out_char;
            o_token_end   = i_head.token_end;
            o_token_start = i_head.token_start;
            o_line_end    = i_head.line_end;
            o_token_count = i_head.token_count;
            o_last        = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= 1'b0;
        end else begin
            r_half <= n_half;
        end
    end

    a_half_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (!i_empty && i_head.dbl))
        else $error("second half without a paired request");

    a_half_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_half && !i_pop) |=> r_half)
        else $error("second half dropped while stalled");

endmodule

`default_nettype wire

FILE: rtl/core/quoted_token_splitter.sv
// Each result is written into the request queue; it is at the ports (empty low) at the head.
// Throughput: one byte per cycle in while the queue is not full; one result per cycle
//   out while pop is high; a token end with a single-character token yields two results.
// A 4-entry request queue between the classifier and the result stage sets the slack.
// Reset (synchronous, active low) empties the queue, clears line state and
//   loads the default character sets.
`default_nettype none

module quoted_token_splitter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_ch,
    output logic             empty,
    input  wire logic        pop,
    output logic             o_has_char,
    output logic [7:0]       o_out_char,
    output logic             o_token_end,
    output logic [9:0]       o_token_start,
    output logic             o_line_end,
    output logic [9:0]       o_token_count,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire qts_pkg::t_cfg_idx i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);
    import qts_pkg::*;

    t_cfg r_cfg;
    t_rec rec, head;
    logic rec_push, q_pop, accept;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.separator  <= RST_SEPARATOR;
            r_cfg.single     <= RST_SINGLE;
            r_cfg.comment    <= RST_COMMENT;
            r_cfg.quote      <= RST_QUOTE;
            r_cfg.quote_ends <= RST_QUOTE_ENDS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SEPARATOR:  r_cfg.separator  <= i_cfg_data;
                CFG_SINGLE:     r_cfg.single     <= i_cfg_data;
                CFG_COMMENT:    r_cfg.comment    <= i_cfg_data;
                CFG_QUOTE:      r_cfg.quote      <= i_cfg_data[31:0];
                CFG_QUOTE_ENDS: r_cfg.quote_ends <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    qts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_ch       (i_ch),
        .i_cfg      (r_cfg),
        .o_rec      (rec),
        .o_rec_push (rec_push)
    );

    qts_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_rec   (rec),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_head  (head),
        .o_empty (empty)
    );

    qts_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_empty       (empty),
        .i_pop         (pop),
        .o_q_pop       (q_pop),
        .o_has_char    (o_has_char),
        .o_out_char    (o_out_char),
        .o_token_end   (o_token_end),
        .o_token_start (o_token_start),
        .o_line_end    (o_line_end),
        .o_token_count (o_token_count),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

FILE: bench/quoted_token_splitter_test.sv
`default_nettype none

module quoted_token_splitter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import qts_pkg::*;

    typedef struct {
        logic  has_char;
        t_byte out_char;
        logic  token_end;
        t_cnt  token_start;
        logic  line_end;
        t_cnt  token_count;
        logic  last;
    } t_token_result;

    logic        i_clk;
    logic        rst_n       = 1'b0;
    logic        push        = 1'b0;
    t_byte       ch          = CH_NUL;
    logic        pop         = 1'b0;
    logic        cfg_valid   = 1'b0;
    t_cfg_idx    cfg_index   = CFG_SEPARATOR;
    logic [63:0] cfg_data    = '0;

    logic        full;
    logic        empty;
    logic        o_has_char;
    logic [7:0]  o_out_char;
    logic        o_token_end;
    logic [9:0]  o_token_start;
    logic        o_line_end;
    logic [9:0]  o_token_count;
    logic        o_last;
    logic        o_cfg_ready;

    quoted_token_splitter dut (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .push         (push),
        .full         (full),
        .i_ch         (ch),
        .empty        (empty),
        .pop          (pop),
        .o_has_char   (o_has_char),
        .o_out_char   (o_out_char),
        .o_token_end  (o_token_end),
        .o_token_start(o_token_start),
        .o_line_end   (o_line_end),
        .o_token_count(o_token_count),
        .o_last       (o_last),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    // tokenizer model state
    logic [63:0] sep_set;
    logic [63:0] single_set;
    logic [63:0] comment_set;
    logic [31:0] quote_set;
    logic        quote_ends;
    t_mode       scan;
    t_byte       closer;
    t_cnt        line_pos;
    t_cnt        tok_start;
    t_cnt        tok_count;
    logic        first_pending;

    t_token_result step_out[$];
    t_token_result awaited_results[$];
    t_token_result want;

    int errors     = 0;
    int n_bytes    = 0;
    int n_checked  = 0;
    int send_idle  = 0;
    int recv_stall = 0;
    logic hold_off = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Timeout at %0t with %0d results outstanding", $time, awaited_results.size());
        $display("TEST FAILED");
        $finish;
    end

    function automatic bit listed(logic [63:0] set, int slots, t_byte c);
        for (int k = 0; k < slots && k < 8; k++) begin
            if (set[8*k +: 8] != CH_NUL && set[8*k +: 8] == c) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_byte closing_of(t_byte c);
        case (c)
            CH_LBRK: return CH_RBRK;
            CH_LPAR: return CH_RPAR;
            CH_LBRC: return CH_RBRC;
            default: return c;
        endcase
    endfunction

    function automatic t_cnt bump(t_cnt v);
        return (v < CNT_CAP_V) ? v + t_cnt'(1) : CNT_CAP_V;
    endfunction

    function void clear_line();
        scan          = M_BETWEEN;
        closer        = CH_NUL;
        line_pos      = '0;
        tok_start     = '0;
        tok_count     = '0;
        first_pending = 1'b1;
    endfunction

    function void emit(logic hc, t_byte oc, logic te, t_cnt ts, logic le, t_cnt tc);
        t_token_result r;
        if (step_out.size() >= 2) begin
            return;
        end
        r.has_char    = hc;
        r.out_char    = oc;
        r.token_end   = te;
        r.token_start = ts;
        r.line_end    = le;
        r.token_count = tc;
        r.last        = 1'b0;
        step_out.insert(step_out.size(), r);
    endfunction

    function void close_token();
        tok_count = bump(tok_count);
        emit(1'b0, CH_NUL, 1'b1, tok_start, 1'b0, '0);
        scan = M_BETWEEN;
    endfunction

    function void take_content(t_byte c);
        if (first_pending) begin
            first_pending = 1'b0;
            if (listed(comment_set, SET_SLOTS, c)) begin
                scan = M_DISCARD;
                return;
            end
        end
        emit(1'b1, c, 1'b0, '0, 1'b0, '0);
    endfunction

    function void lone_token(t_byte c, t_cnt pos);
        if (listed(comment_set, SET_SLOTS, c)) begin
            scan = M_DISCARD;
            return;
        end
        tok_count = bump(tok_count);
        emit(1'b1, c, 1'b1, pos, 1'b0, '0);
        scan = M_BETWEEN;
    endfunction

    function void open_quote(t_byte c);
        closer = closing_of(c);
        scan   = M_QUOTE;
    endfunction

    function void tokenize_byte(t_byte c);
        t_cnt pos;
        logic te;
        pos = line_pos;
        step_out.delete();
        if (c == CH_NUL) begin
            te = (scan == M_TOKEN || scan == M_QUOTE);
            if (te) begin
                tok_count = bump(tok_count);
            end
            emit(1'b0, CH_NUL, te, te ? tok_start : t_cnt'(0), 1'b1, tok_count);
            clear_line();
        end else begin
            case (scan)
                M_QUOTE: begin
                    if (c == closer) begin
                        if (quote_ends) close_token();
                        else scan = M_TOKEN;
                    end else begin
                        take_content(c);
                    end
                end
                M_TOKEN: begin
                    if (listed(sep_set, SET_SLOTS, c)) begin
                        close_token();
                    end else if (listed(single_set, SET_SLOTS, c)) begin
                        close_token();
                        lone_token(c, pos);
                    end else if (listed({32'h0, quote_set}, QUOTE_SLOTS, c)) begin
                        open_quote(c);
                    end else begin
                        take_content(c);
                    end
                end
                M_BETWEEN: begin
                    if (listed(sep_set, SET_SLOTS, c)) begin
                    end else if (listed(single_set, SET_SLOTS, c)) begin
                        lone_token(c, pos);
                    end else begin
                        tok_start     = pos;
                        first_pending = 1'b1;
                        scan          = M_TOKEN;
                        if (listed({32'h0, quote_set}, QUOTE_SLOTS, c)) open_quote(c);
                        else take_content(c);
                    end
                end
                default: begin
                end
            endcase
            line_pos = bump(pos);
        end
        if (step_out.size() > 0) begin
            step_out[step_out.size()-1].last = 1'b1;
        end
        foreach (step_out[i]) begin
            awaited_results.insert(awaited_results.size(), step_out[i]);
        end
    endfunction

    function void check_field(string name, int unsigned exp_v, int unsigned got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
            errors++;
        end
    endfunction

    // result checker and receiver pacing
    always @(posedge i_clk) begin
        if (rst_n && pop && !empty) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got char %0d end %0b line %0b",
                         $time, o_out_char, o_token_end, o_line_end);
                errors++;
            end else begin
                want = awaited_results[0];
                awaited_results.delete(0);
                check_field("has_char", want.has_char, o_has_char);
                check_field("out_char", want.out_char, o_out_char);
                check_field("token_end", want.token_end, o_token_end);
                check_field("token_start", want.token_start, o_token_start);
                check_field("line_end", want.line_end, o_line_end);
                check_field("token_count", want.token_count, o_token_count);
                check_field("last", want.last, o_last);
                n_checked++;
            end
        end
        pop <= !hold_off && ($urandom_range(0, 99) >= recv_stall);
    end

    task automatic send_byte(t_byte b);
        while ($urandom_range(0, 99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        ch   <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        tokenize_byte(b);
        n_bytes++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    task automatic settle();
        push <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SEPARATOR:  sep_set     = val;
            CFG_SINGLE:     single_set  = val;
            CFG_COMMENT:    comment_set = val;
            CFG_QUOTE:      quote_set   = val[31:0];
            CFG_QUOTE_ENDS: quote_ends  = val[0];
            default: begin
            end
        endcase
        @(posedge i_clk);
    endtask

    function automatic t_byte pick_char(string pool);
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    function automatic logic [63:0] rand_set(string pool);
        logic [63:0] v;
        v = '0;
        for (int k = 0; k < 8; k++) begin
            case ($urandom_range(0, 3))
                0:       v[8*k +: 8] = CH_NUL;
                3:       v[8*k +: 8] = t_byte'($urandom_range(1, 255));
                default: v[8*k +: 8] = pick_char(pool);
            endcase
        end
        return v;
    endfunction

    function automatic t_byte pick_slot(logic [63:0] set, int slots, t_byte dflt);
        t_byte found[$];
        for (int k = 0; k < slots && k < 8; k++) begin
            if (set[8*k +: 8] != CH_NUL) found.insert(found.size(), set[8*k +: 8]);
        end
        if (found.size() == 0) return dflt;
        return found[$urandom_range(0, found.size() - 1)];
    endfunction

    function automatic t_byte word_byte();
        if ($urandom_range(0, 9) < 7) return t_byte'($urandom_range(8'h61, 8'h7A));
        return t_byte'($urandom_range(1, 255));
    endfunction

    task automatic send_line();
        int    ntok;
        t_byte q;
        ntok = $urandom_range(1, 6);
        for (int t = 0; t < ntok; t++) begin
            repeat ($urandom_range(0, 2)) send_byte(pick_slot(sep_set, SET_SLOTS, " "));
            case ($urandom_range(0, 9))
                5, 6: begin
                    q = pick_slot({32'h0, quote_set}, QUOTE_SLOTS, "\"");
                    repeat ($urandom_range(0, 1)) send_byte(word_byte());
                    send_byte(q);
                    repeat ($urandom_range(0, 4)) begin
                        if ($urandom_range(0, 3) == 0) send_byte(pick_slot(sep_set, 8, " "));
                        else send_byte(word_byte());
                    end
                    if ($urandom_range(0, 3) != 0) send_byte(closing_of(q));
                    repeat ($urandom_range(0, 1)) send_byte(word_byte());
                end
                7: send_byte(pick_slot(single_set, SET_SLOTS, ","));
                8: begin
                    send_byte(pick_slot(comment_set, SET_SLOTS, "#"));
                    repeat ($urandom_range(0, 3)) send_byte(word_byte());
                end
                9: send_byte(t_byte'($urandom_range(1, 255)));
                default: repeat ($urandom_range(1, 5)) send_byte(word_byte());
            endcase
        end
        send_byte(CH_NUL);
    endtask

    task automatic send_noise_line();
        repeat ($urandom_range(1, 20)) send_byte(t_byte'($urandom_range(0, 255)));
        send_byte(CH_NUL);
    endtask

    // default sets: extremes, empty quoted token, comment token
    task automatic test_defaults();
        send_byte(8'h01);
        send_byte(8'hFF);
        send_text(" \"\"a# #z");
        send_byte(CH_NUL);
    endtask

    // single-char tokens, brackets, non-terminal quotes, open tokens at line end
    task automatic test_sets();
        settle();
        write_reg(CFG_SINGLE, 64'h20_23_2C_3B);
        write_reg(CFG_QUOTE, 64'hA5A5_A5A5_007B_285B);
        write_reg(CFG_QUOTE_ENDS, 64'h0);
        write_reg(CFG_COMMENT, 64'h23);
        send_text("b, [c ]d(x");
        send_byte(CH_NUL);
        send_text(";#k");
        send_byte(CH_NUL);
    endtask

    // position and token counters saturate
    task automatic test_saturation();
        repeat (1040) send_byte(",");
        send_text("a");
        send_byte(CH_NUL);
    endtask

    task automatic test_extreme_sets();
        settle();
        write_reg(CFG_SEPARATOR, '0);
        write_reg(CFG_SINGLE, '0);
        write_reg(CFG_COMMENT, '0);
        write_reg(CFG_QUOTE, '0);
        write_reg(CFG_QUOTE_ENDS, '0);
        repeat (30) send_byte(t_byte'($urandom_range(1, 255)));
        send_byte(CH_NUL);
        settle();
        write_reg(CFG_SEPARATOR, '1);
        write_reg(CFG_SINGLE, '1);
        write_reg(CFG_COMMENT, '1);
        write_reg(CFG_QUOTE, '1);
        write_reg(CFG_QUOTE_ENDS, '1);
        repeat (30) begin
            if ($urandom_range(0, 3) == 0) send_byte(8'hFF);
            else send_byte(t_byte'($urandom_range(1, 255)));
        end
        send_byte(CH_NUL);
    endtask

    task automatic test_random_lines();
        int sender_pct[4] = '{0, 45, 0, 9};
        int stall_pct[4]  = '{0, 0, 45, 9};
        int target;
        for (int p = 0; p < 4; p++) begin
            settle();
            write_reg(CFG_SEPARATOR, rand_set(" \t\r\n,;:|"));
            write_reg(CFG_SINGLE, rand_set(",;=+-*/!"));
            write_reg(CFG_COMMENT, rand_set("#%!;"));
            write_reg(CFG_QUOTE, {32'($urandom), 32'(rand_set("\"'[({`<"))});
            write_reg(CFG_QUOTE_ENDS, 64'($urandom_range(0, 1)));
            send_idle  = sender_pct[p];
            recv_stall <= stall_pct[p];
            target = n_bytes + 150;
            while (n_bytes < target) begin
                if ($urandom_range(0, 9) == 0) send_noise_line();
                else send_line();
            end
        end
    endtask

    // receiver holds off long enough for the queue to fill and stall input
    task automatic test_backpressure();
        settle();
        send_idle  = 0;
        recv_stall <= 0;
        fork
            begin
                hold_off <= 1'b1;
                repeat (200) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            begin
                repeat (3) begin
                    repeat (20) send_byte(t_byte'($urandom_range(8'h61, 8'h7A)));
                    send_byte(CH_NUL);
                end
            end
        join
    endtask

    initial begin
        sep_set     = RST_SEPARATOR;
        single_set  = RST_SINGLE;
        comment_set = RST_COMMENT;
        quote_set   = RST_QUOTE;
        quote_ends  = RST_QUOTE_ENDS;
        clear_line();
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_sets();
        test_saturation();
        test_extreme_sets();
        test_random_lines();
        test_backpressure();
        settle();

        $display("Sent %0d bytes and checked %0d results over default, bracket,", n_bytes,
                 n_checked);
        $display("saturating, all-zero/all-one and random character sets with back-pressure");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
